// ===== rtl/core/stoc_pkg.sv =====
// shared types and constants for the strided tensor overlap classifier
// no dependencies; used by the top level and its checker
`default_nettype none
package stoc_pkg;

    localparam int MAX_RANK = 8;
    localparam int IDX_W    = $clog2(MAX_RANK);
    localparam int RANK_W   = $clog2(MAX_RANK + 1);
    localparam int S_DATA_W = 304;
    localparam int M_DATA_W = 8;

    // command codes carried in s_tuser
    localparam logic [2:0] CMD_REQ_HDR  = 3'd0;
    localparam logic [2:0] CMD_ENT_HDR  = 3'd1;
    localparam logic [2:0] CMD_REQ_DIM  = 3'd2;
    localparam logic [2:0] CMD_ENT_DIM  = 3'd3;
    localparam logic [2:0] CMD_CLASSIFY = 3'd4;

    // result codes
    localparam logic [1:0] CLS_NONE    = 2'd0;
    localparam logic [1:0] CLS_COVERED = 2'd1;
    localparam logic [1:0] CLS_OTHER   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_VER,
        S_EXT,
        S_OVL,
        S_STR,
        S_RDIV,
        S_RDONE,
        S_NUM0,
        S_NUM1,
        S_NUM2,
        S_OFFA,
        S_OFFA2,
        S_OFFB2,
        S_BND,
        S_INT,
        S_DIV
    } state_t;

    // out-of-band results use a separate flag rather than an extra state
endpackage
`default_nettype wire

// ===== rtl/core/strided_tensor_overlap_classifier_top.sv =====
// top level of the strided tensor overlap classifier: loader, sequencer,
// bit-serial multiplier and restoring divider; depends on stoc_pkg
//
// usage: items enter on the s_ channel, s_tuser holds the command.
// header and dimension items each load part of one view record and give
// no result. a classify item gives one result item on the m_ channel,
// m_tdata[1:0] = 0 none, 1 covered, 2 other.
// classify steps: the version check, the extent products (shift-and-add
// over all eight dimension slots) and the linear overlap check, a stride
// check per dimension, the stride ratios (rank-1 of them, each a division
// plus setup and check), the reference outer shape (two divisions) and the
// offsets (two divisions per dimension), the bound and interval passes over
// the dimensions, and loading the result. an early decision (version, no
// linear overlap, layout mismatch) ends it sooner.
// one item is in work at a time; s_tready is high only while idle.
// reset clears all loaded records to zero and drops any pending result.
// when the receiver stalls, the result stays in the output register and the
// block still takes load items; a further classify waits at its end until
// the output register is free.
`default_nettype none
module strided_tensor_overlap_classifier_top (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    // base_offset, version, elem_bytes, total_bytes, dim_count, contiguous,
    // cached_extent, dim_index, dim_shape, dim_stride
    input  wire [stoc_pkg::S_DATA_W-1:0]   s_tdata,
    // cmd
    input  wire [2:0]                      s_tuser,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    // overlap_class, zero fill
    output logic [stoc_pkg::M_DATA_W-1:0]  m_tdata
);

    localparam int IW = stoc_pkg::IDX_W;
    localparam int RW = stoc_pkg::RANK_W;

    // input fields
    logic [63:0] in_start, in_tb, in_ce;
    logic [31:0] in_ver, in_shape, in_stride;
    logic [7:0]  in_eb;
    logic [3:0]  in_dc;
    logic        in_ct;
    logic [2:0]  in_di;
    logic [RW-1:0] in_rank;

    assign in_start  = s_tdata[63:0];
    assign in_ver    = s_tdata[95:64];
    assign in_eb     = s_tdata[103:96];
    assign in_tb     = s_tdata[167:104];
    assign in_dc     = s_tdata[171:168];
    assign in_ct     = s_tdata[172];
    assign in_ce     = s_tdata[236:173];
    assign in_di     = s_tdata[239:237];
    assign in_shape  = s_tdata[271:240];
    assign in_stride = s_tdata[303:272];
    assign in_rank   = (32'(in_dc) > stoc_pkg::MAX_RANK) ? RW'(stoc_pkg::MAX_RANK)
                                                         : RW'(in_dc);

    // view records
    logic [63:0] req_start_reg, ent_start_reg, req_tb_reg, req_ext_reg, ent_ext_reg;
    logic [31:0] req_ver_reg, ent_ver_reg;
    logic [7:0]  req_eb_reg, ent_eb_reg;
    logic [RW-1:0] req_rank_reg, ent_rank_reg;
    logic        req_contig_reg, ent_contig_reg;
    logic [31:0] req_shapes_reg  [stoc_pkg::MAX_RANK];
    logic [31:0] ent_shapes_reg  [stoc_pkg::MAX_RANK];
    logic [31:0] req_strides_reg [stoc_pkg::MAX_RANK];
    logic [31:0] ent_strides_reg [stoc_pkg::MAX_RANK];

    // per-dimension work values
    logic [63:0] ref_mem  [stoc_pkg::MAX_RANK];
    logic [63:0] aoff_mem [stoc_pkg::MAX_RANK];
    logic [63:0] boff_mem [stoc_pkg::MAX_RANK];
    logic        ref_we, aoff_we, boff_we;
    logic [IW-1:0] wr_idx;
    logic [63:0] wr_data;

    stoc_pkg::state_t state_reg, state_next, ret_reg, ret_next;
    logic [RW-1:0] idx_reg, idx_next;
    logic [4:0]  bit_reg, bit_next;
    logic [63:0] rprod_reg, rprod_next, eprod_reg, eprod_next;
    logic [63:0] rsum_reg, rsum_next, esum_reg, esum_next;
    logic [63:0] rmul_reg, rmul_next, emul_reg, emul_next;
    logic [63:0] ra_reg, ra_next, rb_reg, rb_next;
    logic [63:0] dv_num_reg, dv_num_next, dv_rem_reg, dv_rem_next;
    logic [63:0] dv_den_reg, dv_den_next;
    logic [5:0]  dv_cnt_reg, dv_cnt_next;
    logic        covers_reg, covers_next;
    logic [1:0]  cls_reg, cls_next;
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_cls_reg, m_cls_next;

    logic        in_fire;
    assign s_tready = (state_reg == stoc_pkg::S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(stoc_pkg::M_DATA_W-2){1'b0}}, m_cls_reg};

    // record loads
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_start_reg  <= '0;
            ent_start_reg  <= '0;
            req_tb_reg     <= '0;
            req_ext_reg    <= '0;
            ent_ext_reg    <= '0;
            req_ver_reg    <= '0;
            ent_ver_reg    <= '0;
            req_eb_reg     <= '0;
            ent_eb_reg     <= '0;
            req_rank_reg   <= '0;
            ent_rank_reg   <= '0;
            req_contig_reg <= 1'b0;
            ent_contig_reg <= 1'b0;
            for (int k = 0; k < stoc_pkg::MAX_RANK; k++) begin
                req_shapes_reg[k]  <= '0;
                ent_shapes_reg[k]  <= '0;
                req_strides_reg[k] <= '0;
                ent_strides_reg[k] <= '0;
            end
        end else if (in_fire) begin
            case (s_tuser)
                stoc_pkg::CMD_REQ_HDR: begin
                    req_start_reg  <= in_start;
                    req_ver_reg    <= in_ver;
                    req_eb_reg     <= in_eb;
                    req_tb_reg     <= in_tb;
                    req_rank_reg   <= in_rank;
                    req_contig_reg <= in_ct;
                    req_ext_reg    <= in_ce;
                end
                stoc_pkg::CMD_ENT_HDR: begin
                    ent_start_reg  <= in_start;
                    ent_ver_reg    <= in_ver;
                    ent_eb_reg     <= in_eb;
                    ent_rank_reg   <= in_rank;
                    ent_contig_reg <= in_ct;
                    ent_ext_reg    <= in_ce;
                end
                stoc_pkg::CMD_REQ_DIM: begin
                    if (32'(in_di) < stoc_pkg::MAX_RANK) begin
                        req_shapes_reg[IW'(in_di)]  <= in_shape;
                        req_strides_reg[IW'(in_di)] <= in_stride;
                    end
                end
                stoc_pkg::CMD_ENT_DIM: begin
                    if (32'(in_di) < stoc_pkg::MAX_RANK) begin
                        ent_shapes_reg[IW'(in_di)]  <= in_shape;
                        ent_strides_reg[IW'(in_di)] <= in_stride;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (ref_we)  ref_mem[wr_idx]  <= wr_data;
        if (aoff_we) aoff_mem[wr_idx] <= wr_data;
        if (boff_we) boff_mem[wr_idx] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= stoc_pkg::S_IDLE;
            ret_reg     <= stoc_pkg::S_IDLE;
            idx_reg     <= '0;
            bit_reg     <= '0;
            dv_cnt_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            idx_reg     <= idx_next;
            bit_reg     <= bit_next;
            dv_cnt_reg  <= dv_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rprod_reg  <= rprod_next;
        eprod_reg  <= eprod_next;
        rsum_reg   <= rsum_next;
        esum_reg   <= esum_next;
        rmul_reg   <= rmul_next;
        emul_reg   <= emul_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        dv_num_reg <= dv_num_next;
        dv_rem_reg <= dv_rem_next;
        dv_den_reg <= dv_den_next;
        covers_reg <= covers_next;
        cls_reg    <= cls_next;
        m_cls_reg  <= m_cls_next;
    end

    logic [IW-1:0] idx, idx_m1;
    logic [RW-1:0] last_idx;
    logic [31:0] rsh, esh, est, est_m1, rst;
    logic [63:0] rmul_src, emul_src, rsum_src, esum_src, rnew, enew;
    logic        r_act, e_act;
    logic [63:0] aext, bext, a_end, b_end;
    logic [64:0] dv_part;
    logic        dv_ge;
    logic [63:0] refv, a0, b0, a1, b1, sa, sb;

    always_comb begin
        idx      = idx_reg[IW-1:0];
        idx_m1   = IW'(idx_reg - RW'(1));
        last_idx = req_rank_reg - RW'(1);
        rsh      = req_shapes_reg[idx];
        esh      = ent_shapes_reg[idx];
        rst      = req_strides_reg[idx];
        est      = ent_strides_reg[idx];
        est_m1   = ent_strides_reg[idx_m1];

        // extent product, one multiplier bit per cycle
        r_act    = req_contig_reg && (idx_reg < req_rank_reg);
        e_act    = ent_contig_reg && (idx_reg < ent_rank_reg);
        rmul_src = (bit_reg == 5'd0) ? rprod_reg : rmul_reg;
        emul_src = (bit_reg == 5'd0) ? eprod_reg : emul_reg;
        rsum_src = (bit_reg == 5'd0) ? 64'd0 : rsum_reg;
        esum_src = (bit_reg == 5'd0) ? 64'd0 : esum_reg;
        rnew     = rsum_src + (rsh[bit_reg] ? rmul_src : 64'd0);
        enew     = esum_src + (esh[bit_reg] ? emul_src : 64'd0);

        aext  = req_contig_reg ? rprod_reg : req_ext_reg;
        bext  = ent_contig_reg ? eprod_reg : ent_ext_reg;
        a_end = req_start_reg + aext;
        b_end = ent_start_reg + bext;

        // restoring divider step
        dv_part = {dv_rem_reg, dv_num_reg[63]};
        dv_ge   = dv_part >= {1'b0, dv_den_reg};

        refv = ref_mem[idx];
        a0   = aoff_mem[idx];
        b0   = boff_mem[idx];
        sa   = {32'd0, rsh};
        sb   = {32'd0, esh};
        a1   = a0 + sa;
        b1   = b0 + sb;

        state_next   = state_reg;
        ret_next     = ret_reg;
        idx_next     = idx_reg;
        bit_next     = bit_reg;
        rprod_next   = rprod_reg;
        eprod_next   = eprod_reg;
        rsum_next    = rsum_reg;
        esum_next    = esum_reg;
        rmul_next    = rmul_reg;
        emul_next    = emul_reg;
        ra_next      = ra_reg;
        rb_next      = rb_reg;
        dv_num_next  = dv_num_reg;
        dv_rem_next  = dv_rem_reg;
        dv_den_next  = dv_den_reg;
        dv_cnt_next  = dv_cnt_reg;
        covers_next  = covers_reg;
        cls_next     = cls_reg;
        m_cls_next   = m_cls_reg;
        m_valid_next = m_valid_reg && !m_tready;
        ref_we       = 1'b0;
        aoff_we      = 1'b0;
        boff_we      = 1'b0;
        wr_idx       = idx;
        wr_data      = dv_num_reg;

        case (state_reg)
            stoc_pkg::S_IDLE: begin
                if (in_fire && s_tuser == stoc_pkg::CMD_CLASSIFY) begin
                    state_next = stoc_pkg::S_VER;
                end
            end
            stoc_pkg::S_VER: begin
                idx_next   = '0;
                bit_next   = '0;
                rprod_next = 64'd1;
                eprod_next = 64'd1;
                if (req_ver_reg > ent_ver_reg) begin
                    cls_next   = stoc_pkg::CLS_OTHER;
                    state_next = stoc_pkg::S_INT;
                    idx_next   = RW'(stoc_pkg::MAX_RANK);
                    covers_next = 1'b0;
                end else begin
                    state_next = stoc_pkg::S_EXT;
                end
            end
            stoc_pkg::S_EXT: begin
                rsum_next = rnew;
                esum_next = enew;
                rmul_next = rmul_src << 1;
                emul_next = emul_src << 1;
                bit_next  = bit_reg + 5'd1;
                if (bit_reg == 5'd31) begin
                    if (r_act) rprod_next = rnew;
                    if (e_act) eprod_next = enew;
                    if (idx == IW'(stoc_pkg::MAX_RANK - 1)) begin
                        idx_next   = '0;
                        state_next = stoc_pkg::S_OVL;
                    end else begin
                        idx_next = idx_reg + RW'(1);
                    end
                end
            end
            stoc_pkg::S_OVL: begin
                idx_next = '0;
                if (!(a_end > ent_start_reg && b_end > req_start_reg)) begin
                    cls_next   = stoc_pkg::CLS_NONE;
                    state_next = stoc_pkg::S_INT;
                    idx_next   = RW'(stoc_pkg::MAX_RANK);
                end else if (req_eb_reg != ent_eb_reg || req_rank_reg != ent_rank_reg ||
                             req_rank_reg == '0) begin
                    cls_next   = stoc_pkg::CLS_OTHER;
                    state_next = stoc_pkg::S_INT;
                    idx_next   = RW'(stoc_pkg::MAX_RANK);
                end else begin
                    state_next = stoc_pkg::S_STR;
                end
                covers_next = 1'b0;
            end
            stoc_pkg::S_STR: begin
                if (rst != est || est == 32'd0 ||
                    (idx_reg == last_idx && est != 32'd1)) begin
                    cls_next   = stoc_pkg::CLS_OTHER;
                    state_next = stoc_pkg::S_INT;
                    idx_next   = RW'(stoc_pkg::MAX_RANK);
                end else if (idx_reg == last_idx) begin
                    idx_next   = RW'(1);
                    state_next = (req_rank_reg > RW'(1)) ? stoc_pkg::S_RDIV
                                                         : stoc_pkg::S_NUM0;
                end else begin
                    idx_next = idx_reg + RW'(1);
                end
            end
            stoc_pkg::S_RDIV: begin
                dv_num_next = {32'd0, est_m1};
                dv_den_next = {32'd0, est};
                dv_rem_next = '0;
                dv_cnt_next = '0;
                ret_next    = stoc_pkg::S_RDONE;
                state_next  = stoc_pkg::S_DIV;
            end
            stoc_pkg::S_RDONE: begin
                if (dv_rem_reg != 64'd0) begin
                    cls_next   = stoc_pkg::CLS_OTHER;
                    state_next = stoc_pkg::S_INT;
                    idx_next   = RW'(stoc_pkg::MAX_RANK);
                end else begin
                    ref_we = 1'b1;
                    if (idx_reg == last_idx) begin
                        state_next = stoc_pkg::S_NUM0;
                    end else begin
                        idx_next   = idx_reg + RW'(1);
                        state_next = stoc_pkg::S_RDIV;
                    end
                end
            end
            stoc_pkg::S_NUM0: begin
                idx_next = '0;
                if (req_eb_reg == 8'd0) begin
                    // zero element bytes: outer shape is zero
                    ref_we     = 1'b1;
                    wr_idx     = '0;
                    wr_data    = 64'd0;
                    ra_next    = req_start_reg;
                    rb_next    = ent_start_reg;
                    state_next = stoc_pkg::S_OFFA;
                end else begin
                    dv_num_next = req_tb_reg;
                    dv_den_next = {56'd0, req_eb_reg};
                    dv_rem_next = '0;
                    dv_cnt_next = '0;
                    ret_next    = stoc_pkg::S_NUM1;
                    state_next  = stoc_pkg::S_DIV;
                end
            end
            stoc_pkg::S_NUM1: begin
                dv_num_next = dv_num_reg;
                dv_den_next = {32'd0, ent_strides_reg[0]};
                dv_rem_next = '0;
                dv_cnt_next = '0;
                ret_next    = stoc_pkg::S_NUM2;
                state_next  = stoc_pkg::S_DIV;
            end
            stoc_pkg::S_NUM2: begin
                if (dv_rem_reg != 64'd0) begin
                    cls_next   = stoc_pkg::CLS_OTHER;
                    state_next = stoc_pkg::S_INT;
                    idx_next   = RW'(stoc_pkg::MAX_RANK);
                end else begin
                    ref_we     = 1'b1;
                    wr_idx     = '0;
                    ra_next    = req_start_reg;
                    rb_next    = ent_start_reg;
                    idx_next   = '0;
                    state_next = stoc_pkg::S_OFFA;
                end
            end
            stoc_pkg::S_OFFA: begin
                dv_num_next = ra_reg;
                dv_den_next = {32'd0, est};
                dv_rem_next = '0;
                dv_cnt_next = '0;
                ret_next    = stoc_pkg::S_OFFA2;
                state_next  = stoc_pkg::S_DIV;
            end
            stoc_pkg::S_OFFA2: begin
                aoff_we     = 1'b1;
                ra_next     = dv_rem_reg;
                dv_num_next = rb_reg;
                dv_den_next = {32'd0, est};
                dv_rem_next = '0;
                dv_cnt_next = '0;
                ret_next    = stoc_pkg::S_OFFB2;
                state_next  = stoc_pkg::S_DIV;
            end
            stoc_pkg::S_OFFB2: begin
                boff_we = 1'b1;
                rb_next = dv_rem_reg;
                if (idx_reg == last_idx) begin
                    idx_next = '0;
                    if (ra_reg != 64'd0 || dv_rem_reg != 64'd0) begin
                        cls_next   = stoc_pkg::CLS_OTHER;
                        state_next = stoc_pkg::S_INT;
                        idx_next   = RW'(stoc_pkg::MAX_RANK);
                    end else begin
                        state_next = stoc_pkg::S_BND;
                    end
                end else begin
                    idx_next   = idx_reg + RW'(1);
                    state_next = stoc_pkg::S_OFFA;
                end
            end
            stoc_pkg::S_BND: begin
                if (sa > refv || a0 > refv - sa || sb > refv || b0 > refv - sb) begin
                    cls_next   = stoc_pkg::CLS_OTHER;
                    state_next = stoc_pkg::S_INT;
                    idx_next   = RW'(stoc_pkg::MAX_RANK);
                end else if (idx_reg == last_idx) begin
                    idx_next    = '0;
                    covers_next = 1'b1;
                    cls_next    = stoc_pkg::CLS_OTHER;
                    state_next  = stoc_pkg::S_INT;
                end else begin
                    idx_next = idx_reg + RW'(1);
                end
            end
            stoc_pkg::S_INT: begin
                // idx at MAX_RANK means the class is already settled: hand it out
                if (idx_reg == RW'(stoc_pkg::MAX_RANK)) begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_next = 1'b1;
                        m_cls_next   = covers_reg ? stoc_pkg::CLS_COVERED : cls_reg;
                        state_next   = stoc_pkg::S_IDLE;
                    end
                end else if (!(a1 > b0 && b1 > a0)) begin
                    cls_next    = stoc_pkg::CLS_NONE;
                    covers_next = 1'b0;
                    idx_next    = RW'(stoc_pkg::MAX_RANK);
                end else begin
                    if (!(a0 <= b0 && b1 <= a1)) covers_next = 1'b0;
                    if (idx_reg == last_idx) idx_next = RW'(stoc_pkg::MAX_RANK);
                    else idx_next = idx_reg + RW'(1);
                end
            end
            stoc_pkg::S_DIV: begin
                dv_rem_next = dv_ge ? 64'(dv_part - {1'b0, dv_den_reg}) : dv_part[63:0];
                dv_num_next = {dv_num_reg[62:0], dv_ge};
                dv_cnt_next = dv_cnt_reg + 6'd1;
                if (dv_cnt_reg == 6'd63) state_next = ret_reg;
            end
            default: state_next = stoc_pkg::S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/core/stoc_checker.sv =====
// port-level checker for the strided tensor overlap classifier
// depends on stoc_pkg; bound to the top level below
`default_nettype none
module stoc_checker (
    input wire                           aclk,
    input wire                           aresetn,
    input wire                           s_tvalid,
    input wire                           s_tready,
    input wire [stoc_pkg::S_DATA_W-1:0]  s_tdata,
    input wire [2:0]                     s_tuser,
    input wire                           m_tvalid,
    input wire                           m_tready,
    input wire [stoc_pkg::M_DATA_W-1:0]  m_tdata
);

    // no result item right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // result code is one of the three classes
    a_class_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == stoc_pkg::CLS_NONE ||
                      m_tdata[1:0] == stoc_pkg::CLS_COVERED ||
                      m_tdata[1:0] == stoc_pkg::CLS_OTHER))
        else $error("illegal class code");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // a load item never causes a result
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser != stoc_pkg::CMD_CLASSIFY |=> !$rose(m_tvalid))
        else $error("result after load item");

    // an accepted classify closes the input
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == stoc_pkg::CMD_CLASSIFY |=> !s_tready)
        else $error("input open during classify");

endmodule

bind strided_tensor_overlap_classifier_top stoc_checker u_stoc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
